// ===== design/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared types and constants for the rounded rectangle pixel shader.
// ----------------------------------------------------------------------------
package rrps_pkg;

    localparam int SCREEN_W   = 512;
    localparam int SCREEN_H   = 512;
    localparam int COLOR_BITS = 16;

    localparam logic [15:0] COLOR_MASK = 16'((32'd1 << COLOR_BITS) - 32'd1);

    // Local coordinate arithmetic width (covers -4095..4095 with margin)
    localparam int GW = 14;

    typedef enum logic [3:0] {
        REG_ORIGIN_X      = 4'd0,
        REG_ORIGIN_Y      = 4'd1,
        REG_RECT_WIDTH    = 4'd2,
        REG_RECT_HEIGHT   = 4'd3,
        REG_CORNER_RADIUS = 4'd4,
        REG_OUTLINE_WIDTH = 4'd5,
        REG_SHAPE_MODE    = 4'd6,
        REG_PAINT_COLORS  = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_FILL          = 2'd0,
        MODE_ROUND         = 2'd1,
        MODE_OUTLINE       = 2'd2,
        MODE_ROUND_OUTLINE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic        paint;
        logic [17:0] fb_address;
        logic [15:0] pixel_color;
    } pixel_out_t;

    // Corner test: box flag and distance to nearest corner centre per axis
    typedef struct packed {
        logic        box;
        logic [10:0] dx;
        logic [10:0] dy;
    } corner_t;

    typedef struct packed {
        logic [17:0] addr;
        logic        in_rect;
        logic        on_border;
        mode_t       mode;
        corner_t     outer;
        logic        inner_in;
        corner_t     inner;
    } geom_t;

endpackage

// ===== design/rrps_corner.sv =====
// ----------------------------------------------------------------------------
// rrps_corner
// Corner box detection and nearest corner centre distances for one rect.
// ----------------------------------------------------------------------------
module rrps_corner (
    input  logic signed [rrps_pkg::GW-1:0] lx,
    input  logic signed [rrps_pkg::GW-1:0] ly,
    input  logic signed [rrps_pkg::GW-1:0] w,
    input  logic signed [rrps_pkg::GW-1:0] h,
    input  logic signed [rrps_pkg::GW-1:0] r,
    output rrps_pkg::corner_t              corner
);

    logic signed [rrps_pkg::GW-1:0] wr;
    logic signed [rrps_pkg::GW-1:0] hr;
    logic signed [rrps_pkg::GW-1:0] ax0;
    logic signed [rrps_pkg::GW-1:0] ax1;
    logic signed [rrps_pkg::GW-1:0] ay0;
    logic signed [rrps_pkg::GW-1:0] ay1;
    logic signed [rrps_pkg::GW-1:0] dx_full;
    logic signed [rrps_pkg::GW-1:0] dy_full;
    logic                           near_x;
    logic                           near_y;

    function automatic logic signed [rrps_pkg::GW-1:0] abs_gw(
        input logic signed [rrps_pkg::GW-1:0] v
    );
        return v[rrps_pkg::GW-1] ? -v : v;
    endfunction

    always_comb
    begin
        wr     = w - r;
        hr     = h - r;
        near_x = (lx <= r) || (lx >= wr);
        near_y = (ly <= r) || (ly >= hr);
        ax0    = abs_gw(lx - r);
        ax1    = abs_gw(lx - wr);
        ay0    = abs_gw(ly - r);
        ay1    = abs_gw(ly - hr);
        // circles are separable per axis: the closest centre wins
        dx_full = (ax0 < ax1) ? ax0 : ax1;
        dy_full = (ay0 < ay1) ? ay0 : ay1;
        corner.box = near_x && near_y;
        corner.dx  = dx_full[10:0];
        corner.dy  = dy_full[10:0];
    end

endmodule

// ===== design/rrps_geom.sv =====
// ----------------------------------------------------------------------------
// rrps_geom
// First shading stage: clip, local coordinates, rect and border tests,
// corner distances for the outer and inset rects, frame-buffer address.
// ----------------------------------------------------------------------------
module rrps_geom (
    input  rrps_pkg::pixel_in_t pixel,
    input  logic signed [11:0]  origin_x,
    input  logic signed [11:0]  origin_y,
    input  logic [10:0]         rect_width,
    input  logic [10:0]         rect_height,
    input  logic [9:0]          corner_radius,
    input  logic [9:0]          outline_width,
    input  rrps_pkg::mode_t     shape_mode,
    output rrps_pkg::geom_t     geom
);

    localparam int GW = rrps_pkg::GW;

    logic signed [GW-1:0] lx;
    logic signed [GW-1:0] ly;
    logic signed [GW-1:0] w;
    logic signed [GW-1:0] h;
    logic signed [GW-1:0] d;
    logic signed [GW-1:0] r_out;
    logic signed [GW-1:0] r_in;
    logic signed [GW-1:0] iw;
    logic signed [GW-1:0] ih;
    logic signed [GW-1:0] ix;
    logic signed [GW-1:0] iy;
    logic                 onscreen;
    logic [22:0]          addr_full;
    rrps_pkg::corner_t    outer_c;
    rrps_pkg::corner_t    inner_c;

    always_comb
    begin
        lx    = $signed({3'b0, pixel.pixel_x}) - $signed({{2{origin_x[11]}}, origin_x});
        ly    = $signed({3'b0, pixel.pixel_y}) - $signed({{2{origin_y[11]}}, origin_y});
        w     = $signed({3'b0, rect_width});
        h     = $signed({3'b0, rect_height});
        d     = $signed({4'b0, outline_width});
        r_out = $signed({4'b0, corner_radius});
        r_in  = $signed({5'b0, corner_radius[9:1]});
        iw    = w - (d <<< 1);
        ih    = h - (d <<< 1);
        ix    = lx - d;
        iy    = ly - d;

        onscreen = ({1'b0, pixel.pixel_x} < 12'(rrps_pkg::SCREEN_W)) &&
                   ({1'b0, pixel.pixel_y} < 12'(rrps_pkg::SCREEN_H));

        addr_full = 23'(pixel.pixel_y) * 23'(rrps_pkg::SCREEN_W) + 23'(pixel.pixel_x);

        geom.addr      = addr_full[17:0];
        geom.in_rect   = onscreen && !lx[GW-1] && !ly[GW-1] && (lx < w) && (ly < h);
        // right and bottom comparisons are strict
        geom.on_border = (lx < d) || (lx > w - d) || (ly < d) || (ly > h - d);
        geom.mode      = shape_mode;
        geom.outer     = outer_c;
        geom.inner_in  = !ix[GW-1] && !iy[GW-1] && (ix < iw) && (iy < ih);
        geom.inner     = inner_c;
    end

    rrps_corner u_outer (
        .lx     (lx),
        .ly     (ly),
        .w      (w),
        .h      (h),
        .r      (r_out),
        .corner (outer_c)
    );

    rrps_corner u_inner (
        .lx     (ix),
        .ly     (iy),
        .w      (iw),
        .h      (ih),
        .r      (r_in),
        .corner (inner_c)
    );

endmodule

// ===== design/rrps_cover.sv =====
// ----------------------------------------------------------------------------
// rrps_cover
// Second shading stage: corner circle tests and mode select into the
// paint flag, address and colour of one result beat.
// ----------------------------------------------------------------------------
module rrps_cover (
    input  rrps_pkg::geom_t     geom,
    input  logic [9:0]          corner_radius,
    input  logic [31:0]         paint_colors,
    output rrps_pkg::pixel_out_t result
);

    logic [21:0] osq_x;
    logic [21:0] osq_y;
    logic [21:0] isq_x;
    logic [21:0] isq_y;
    logic [19:0] r_sq;
    logic [17:0] rh_sq;
    logic [22:0] o_sum;
    logic [22:0] i_sum;
    logic        outer_hit;
    logic        inner_hit;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        hit;
    logic [15:0] color;

    always_comb
    begin
        osq_x = 22'(geom.outer.dx) * 22'(geom.outer.dx);
        osq_y = 22'(geom.outer.dy) * 22'(geom.outer.dy);
        isq_x = 22'(geom.inner.dx) * 22'(geom.inner.dx);
        isq_y = 22'(geom.inner.dy) * 22'(geom.inner.dy);
        r_sq  = 20'(corner_radius) * 20'(corner_radius);
        rh_sq = 18'(corner_radius[9:1]) * 18'(corner_radius[9:1]);
        o_sum = {1'b0, osq_x} + {1'b0, osq_y};
        i_sum = {1'b0, isq_x} + {1'b0, isq_y};

        outer_hit = !geom.outer.box || (o_sum <= 23'(r_sq));
        inner_hit = geom.inner_in && (!geom.inner.box || (i_sum <= 23'(rh_sq)));

        fg = paint_colors[31:16] & rrps_pkg::COLOR_MASK;
        bg = paint_colors[15:0] & rrps_pkg::COLOR_MASK;

        hit   = 1'b0;
        color = fg;
        case (geom.mode)
            rrps_pkg::MODE_FILL:    hit = geom.in_rect;
            rrps_pkg::MODE_ROUND:   hit = geom.in_rect && outer_hit;
            rrps_pkg::MODE_OUTLINE: hit = geom.in_rect && geom.on_border;
            default:
            begin
                // inset rect in background wins over outer shape
                if (inner_hit)
                begin
                    hit   = geom.in_rect;
                    color = bg;
                end
                else
                begin
                    hit = geom.in_rect && outer_hit;
                end
            end
        endcase

        result.paint       = hit;
        result.fb_address  = hit ? geom.addr : 18'd0;
        result.pixel_color = hit ? color : 16'd0;
    end

endmodule

// ===== design/rounded_rect_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// rounded_rect_pixel_shader
// Per-pixel coverage and colour for one configured (rounded) rectangle.
// ----------------------------------------------------------------------------
//   channel   dir   handshake                  payload
//   pixel     in    pixel_valid/pixel_ready    pixel_in_t  (x, y)
//   result    out   result_valid/result_ready  pixel_out_t (paint, addr, color)
//   cfg       in    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One pixel per clock unless backpressure stalls the pipe. The pixel beat
// loads the input register, then the geometry register and then the result
// register, which presents the result beat. Backpressure on result_ready
// reaches pixel_ready in the same cycle; empty stages keep filling, so
// pixel_ready drops only when all three stages hold beats and result_ready
// is low.
// Reset clears the stage valids and the register set to zero; cfg_ready is
// always high. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module rounded_rect_pixel_shader (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  rrps_pkg::pixel_in_t  pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output rrps_pkg::pixel_out_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic signed [11:0]   origin_x_reg;
    logic signed [11:0]   origin_y_reg;
    logic [10:0]          rect_width_reg;
    logic [10:0]          rect_height_reg;
    logic [9:0]           corner_radius_reg;
    logic [9:0]           outline_width_reg;
    rrps_pkg::mode_t      shape_mode_reg;
    logic [31:0]          paint_colors_reg;

    logic                 s1_valid_reg;
    rrps_pkg::pixel_in_t  s1_pixel_reg;
    logic                 s2_valid_reg;
    rrps_pkg::geom_t      s2_geom_reg;
    rrps_pkg::geom_t      s2_geom_next;
    logic                 s3_valid_reg;
    rrps_pkg::pixel_out_t s3_result_reg;
    rrps_pkg::pixel_out_t s3_result_next;

    logic                 s1_ready;
    logic                 s2_ready;
    logic                 s3_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            outline_width_reg <= '0;
            shape_mode_reg    <= rrps_pkg::MODE_FILL;
            paint_colors_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rrps_pkg::REG_ORIGIN_X:      origin_x_reg      <= cfg_data[11:0];
                rrps_pkg::REG_ORIGIN_Y:      origin_y_reg      <= cfg_data[11:0];
                rrps_pkg::REG_RECT_WIDTH:    rect_width_reg    <= cfg_data[10:0];
                rrps_pkg::REG_RECT_HEIGHT:   rect_height_reg   <= cfg_data[10:0];
                rrps_pkg::REG_CORNER_RADIUS: corner_radius_reg <= cfg_data[9:0];
                rrps_pkg::REG_OUTLINE_WIDTH: outline_width_reg <= cfg_data[9:0];
                rrps_pkg::REG_SHAPE_MODE:
                    shape_mode_reg <= rrps_pkg::mode_t'(cfg_data[1:0]);
                rrps_pkg::REG_PAINT_COLORS:  paint_colors_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage takes a beat when it is empty or its own beat moves on
    assign s3_ready    = !s3_valid_reg || result_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_pixel_reg <= pixel;
        end
        if (s2_ready)
        begin
            s2_geom_reg <= s2_geom_next;
        end
        if (s3_ready)
        begin
            s3_result_reg <= s3_result_next;
        end
    end

    rrps_geom u_geom (
        .pixel         (s1_pixel_reg),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .rect_width    (rect_width_reg),
        .rect_height   (rect_height_reg),
        .corner_radius (corner_radius_reg),
        .outline_width (outline_width_reg),
        .shape_mode    (shape_mode_reg),
        .geom          (s2_geom_next)
    );

    rrps_cover u_cover (
        .geom          (s2_geom_reg),
        .corner_radius (corner_radius_reg),
        .paint_colors  (paint_colors_reg),
        .result        (s3_result_next)
    );

    assign result_valid = s3_valid_reg;
    assign result       = s3_result_reg;

    a_unpainted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.paint |-> result.fb_address == 18'd0 &&
                                          result.pixel_color == 16'd0)
        else $error("unpainted beat carries nonzero address or colour");

    a_color_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.paint |->
            result.pixel_color == (paint_colors_reg[31:16] & rrps_pkg::COLOR_MASK) ||
            result.pixel_color == (paint_colors_reg[15:0] & rrps_pkg::COLOR_MASK))
        else $error("painted colour is neither foreground nor background");

    a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> s1_valid_reg)
        else $error("accepted pixel beat not held in input stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !s2_valid_reg |=> !result_valid)
        else $error("result beat repeated after hand-off");

endmodule

// ===== bench/rrps_checker.sv =====
// ----------------------------------------------------------------------------
// rrps_checker
// Watches the pixel, result and cfg channels of the rounded rect pixel shader.
// It keeps a shadow copy of the registers and works out the expected shade of
// each accepted pixel beat. Each result beat is compared, field by field,
// with the oldest expected shade.
// ----------------------------------------------------------------------------
module rrps_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    input  logic                 pixel_ready,
    input  rrps_pkg::pixel_in_t  pixel,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  rrps_pkg::pixel_out_t result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        rrps_pkg::pixel_in_t  coord;
        rrps_pkg::pixel_out_t shade;
    } shade_entry_t;

    // shadow registers, reset values
    logic signed [11:0] org_x     = '0;
    logic signed [11:0] org_y     = '0;
    logic [10:0]        rect_w    = '0;
    logic [10:0]        rect_h    = '0;
    logic [9:0]         radius    = '0;
    logic [9:0]         thickness = '0;
    rrps_pkg::mode_t    shape     = rrps_pkg::MODE_FILL;
    logic [31:0]        colors    = '0;

    shade_entry_t expected_shades[$];
    int           mismatches = 0;
    int           waiting    = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    function automatic logic near_center(input longint a, input longint b,
                                         input longint cx, input longint cy,
                                         input longint r);
        return (a - cx) * (a - cx) + (b - cy) * (b - cy) <= r * r;
    endfunction

    function automatic logic in_box(input longint lx, input longint ly,
                                    input longint w, input longint h);
        return lx >= 0 && ly >= 0 && lx < w && ly < h;
    endfunction

    // corner boxes only paint within r of one of the four circle centers
    function automatic logic round_cover(input longint lx, input longint ly,
                                         input longint w, input longint h,
                                         input longint r);
        logic corner;
        corner = (lx <= r || lx >= w - r) && (ly <= r || ly >= h - r);
        if (!corner)
            return 1'b1;
        return near_center(lx, ly, r, r, r) || near_center(lx, ly, w - r, r, r) ||
               near_center(lx, ly, w - r, h - r, r) || near_center(lx, ly, r, h - r, r);
    endfunction

    function automatic rrps_pkg::pixel_out_t shade_pixel(input rrps_pkg::pixel_in_t p);
        longint               px, py, lx, ly, w, h, r, d, addr;
        logic [15:0]          fg, bg, color;
        logic                 hit;
        rrps_pkg::pixel_out_t o;
        px = longint'(p.pixel_x);
        py = longint'(p.pixel_y);
        w = longint'(rect_w);
        h = longint'(rect_h);
        r = longint'(radius);
        d = longint'(thickness);
        lx = px - longint'(org_x);
        ly = py - longint'(org_y);
        fg = colors[31:16] & rrps_pkg::COLOR_MASK;
        bg = colors[15:0] & rrps_pkg::COLOR_MASK;
        hit = 1'b0;
        color = '0;
        if (px < rrps_pkg::SCREEN_W && py < rrps_pkg::SCREEN_H &&
            in_box(lx, ly, w, h))
        begin
            case (shape)
                rrps_pkg::MODE_FILL:
                begin
                    hit = 1'b1;
                    color = fg;
                end
                rrps_pkg::MODE_ROUND:
                begin
                    hit = round_cover(lx, ly, w, h, r);
                    color = fg;
                end
                rrps_pkg::MODE_OUTLINE:
                begin
                    // right and bottom edges use strict compares
                    hit = lx < d || lx > w - d || ly < d || ly > h - d;
                    color = fg;
                end
                default:
                begin
                    // inner shape, inset by d with half radius, wins with bg
                    if (in_box(lx - d, ly - d, w - 2 * d, h - 2 * d) &&
                        round_cover(lx - d, ly - d, w - 2 * d, h - 2 * d, r / 2))
                    begin
                        hit = 1'b1;
                        color = bg;
                    end
                    else if (round_cover(lx, ly, w, h, r))
                    begin
                        hit = 1'b1;
                        color = fg;
                    end
                end
            endcase
        end
        o = '0;
        if (hit)
        begin
            addr = py * rrps_pkg::SCREEN_W + px;
            o.paint = 1'b1;
            o.fb_address = addr[17:0];
            o.pixel_color = color;
        end
        return o;
    endfunction

    always @(posedge clk)
    begin : watch
        shade_entry_t want;
        shade_entry_t fresh;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rrps_pkg::REG_ORIGIN_X:      org_x = cfg_data[11:0];
                    rrps_pkg::REG_ORIGIN_Y:      org_y = cfg_data[11:0];
                    rrps_pkg::REG_RECT_WIDTH:    rect_w = cfg_data[10:0];
                    rrps_pkg::REG_RECT_HEIGHT:   rect_h = cfg_data[10:0];
                    rrps_pkg::REG_CORNER_RADIUS: radius = cfg_data[9:0];
                    rrps_pkg::REG_OUTLINE_WIDTH: thickness = cfg_data[9:0];
                    rrps_pkg::REG_SHAPE_MODE:    shape = rrps_pkg::mode_t'(cfg_data[1:0]);
                    rrps_pkg::REG_PAINT_COLORS:  colors = cfg_data;
                    default:                     ;
                endcase
            end
            if (pixel_valid && pixel_ready)
            begin
                fresh.coord = pixel;
                fresh.shade = shade_pixel(pixel);
                expected_shades.push_back(fresh);
            end
            if (result_valid && result_ready)
            begin
                if (expected_shades.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t: expected no beat, ",
                              "actual paint=%0d addr=%0d color=%h"},
                             $time, result.paint, result.fb_address,
                             result.pixel_color);
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (result.paint !== want.shade.paint ||
                        result.fb_address !== want.shade.fb_address ||
                        result.pixel_color !== want.shade.pixel_color)
                    begin
                        mismatches++;
                        $display({"%0t: pixel (%0d,%0d) expected paint=%0d addr=%0d ",
                                  "color=%h, actual paint=%0d addr=%0d color=%h"},
                                 $time, want.coord.pixel_x, want.coord.pixel_y,
                                 want.shade.paint, want.shade.fb_address,
                                 want.shade.pixel_color, result.paint,
                                 result.fb_address, result.pixel_color);
                    end
                end
            end
            waiting = expected_shades.size();
        end
    end

endmodule

// ===== bench/tb_rounded_rect_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// tb_rounded_rect_pixel_shader
// Stimulus and verdict for the rounded rect pixel shader. Directed pixels
// hit the shape edges of every mode, then mostly random shapes are shaded by
// random pixels, mostly clustered around each rectangle. The sender bursts,
// the receiver stalls; the register set changes only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_rounded_rect_pixel_shader;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT      = 400000;
    localparam int         RANDOM_PHASES    = 15;
    localparam int         PIXELS_PER_PHASE = 40;
    localparam logic [3:0] FIRST_UNUSED_REG = 4'd8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_ready;
    rrps_pkg::pixel_in_t  pixel_data = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    rrps_pkg::pixel_out_t result_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [3:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending;

    int cycle_count = 0;
    int burst_left = 0;
    int ready_run = 0;
    int style_left = 0;
    int stall_style = 0;
    bit ready_level = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rounded_rect_pixel_shader uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rrps_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: stall style changes every so often, style 0 never stalls
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            if (style_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(40, 160);
            end
            case (stall_style)
                0:
                begin
                    ready_level = 1'b1;
                    ready_run = 8;
                end
                1:
                begin
                    ready_level = 1'($urandom_range(0, 1));
                    ready_run = $urandom_range(1, 3);
                end
                2:
                begin
                    ready_level = ($urandom_range(0, 7) != 0);
                    ready_run = $urandom_range(1, 4);
                end
                default:
                begin
                    ready_level = !ready_level;
                    ready_run = ready_level ? $urandom_range(1, 10) : $urandom_range(5, 20);
                end
            endcase
        end
        ready_run--;
        if (style_left > 0)
            style_left--;
        result_ready <= ready_level;
    end

    // upper bits beyond the register width get junk half the time
    function automatic logic [31:0] add_junk(input logic [31:0] v, input int bits);
        logic [31:0] keep;
        keep = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        if ($urandom_range(0, 1))
            return (v & keep) | ($urandom() & ~keep);
        return v & keep;
    endfunction

    // cfg_valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic configure(input int ox, input int oy, input int w, input int h,
                             input int r, input int d, input rrps_pkg::mode_t m,
                             input logic [31:0] colors);
        if ($urandom_range(0, 1))
            write_reg(FIRST_UNUSED_REG + 4'($urandom_range(0, 7)), $urandom());
        write_reg(rrps_pkg::REG_ORIGIN_X, add_junk(32'(ox), 12));
        write_reg(rrps_pkg::REG_ORIGIN_Y, add_junk(32'(oy), 12));
        write_reg(rrps_pkg::REG_RECT_WIDTH, add_junk(32'(w), 11));
        write_reg(rrps_pkg::REG_RECT_HEIGHT, add_junk(32'(h), 11));
        write_reg(rrps_pkg::REG_CORNER_RADIUS, add_junk(32'(r), 10));
        write_reg(rrps_pkg::REG_OUTLINE_WIDTH, add_junk(32'(d), 10));
        write_reg(rrps_pkg::REG_SHAPE_MODE, add_junk(32'(m), 2));
        write_reg(rrps_pkg::REG_PAINT_COLORS, colors);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input int x, input int y);
        rrps_pkg::pixel_in_t beat;
        int                  gap;
        beat.pixel_x = 11'(x);
        beat.pixel_y = 11'(y);
        pixel_valid <= 1'b1;
        pixel_data <= beat;
        do @(negedge clk); while (!pixel_ready);
        @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold off the sender until every expected result is back
    task automatic drain();
        pixel_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int              ph, i, x, y;
        int              ox, oy, w, h, r, d;
        rrps_pkg::mode_t m;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: zero size, nothing painted
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        send_pixel(511, 0);
        drain();

        // full-screen fill, offscreen clipping, last address
        configure(0, 0, 2047, 2047, 0, 0, rrps_pkg::MODE_FILL, 32'hFFFF_0000);
        send_pixel(0, 0);
        send_pixel(511, 511);
        send_pixel(512, 3);
        send_pixel(3, 512);
        send_pixel(2047, 2047);
        drain();

        // rounded fill: corner pixel outside the circle, circle center, body
        configure(10, 20, 40, 30, 8, 0, rrps_pkg::MODE_ROUND, 32'h1234_ABCD);
        send_pixel(10, 20);
        send_pixel(18, 28);
        send_pixel(30, 35);
        send_pixel(49, 49);
        drain();

        // outline: right edge compare is strict
        configure(100, 100, 20, 10, 5, 3, rrps_pkg::MODE_OUTLINE, 32'h0F0F_F0F0);
        send_pixel(100, 100);
        send_pixel(110, 105);
        send_pixel(117, 105);
        send_pixel(118, 105);
        drain();

        // rounded outline with a partly offscreen origin
        configure(-5, -7, 60, 50, 12, 4, rrps_pkg::MODE_ROUND_OUTLINE, 32'hF00F_0FF0);
        send_pixel(0, 0);
        send_pixel(10, 10);
        send_pixel(30, 20);
        send_pixel(50, 40);
        send_pixel(54, 42);
        drain();

        // rounded outline whose inner shape is empty
        configure(0, 0, 60, 50, 20, 1023, rrps_pkg::MODE_ROUND_OUTLINE, 32'hFFFF_FFFF);
        send_pixel(30, 25);
        send_pixel(0, 0);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            m = rrps_pkg::mode_t'(ph % 4);
            if (ph == 0)
            begin
                ox = -2048; oy = 2047; w = 2047; h = 0; r = 0; d = 0;
            end
            else if (ph == 1)
            begin
                ox = 2047; oy = -2048; w = 0; h = 2047; r = 1023; d = 1023;
            end
            else if (ph == 2)
            begin
                ox = -1800; oy = -1700; w = 2047; h = 2047; r = 1023; d = 1023;
            end
            else
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(0, 160);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(0, 160);
                ox = int'($urandom_range(0, 600)) - 80;
                oy = int'($urandom_range(0, 600)) - 80;
                r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, (w < h ? w : h) / 2 + 2);
                d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 12);
            end
            configure(ox, oy, w, h, r, d, m, $urandom());
            for (i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    x = ox + int'($urandom_range(0, w + 8)) - 4;
                    y = oy + int'($urandom_range(0, h + 8)) - 4;
                    if (x < 0 || x > 2047)
                        x = $urandom_range(0, 2047);
                    if (y < 0 || y > 2047)
                        y = $urandom_range(0, 2047);
                end
                else
                begin
                    x = $urandom_range(0, 2047);
                    y = $urandom_range(0, 2047);
                end
                send_pixel(x, y);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== rounded_rect_pixel_shader.f =====
design/rrps_pkg.sv
design/rrps_corner.sv
design/rrps_geom.sv
design/rrps_cover.sv
design/rounded_rect_pixel_shader.sv
bench/rrps_checker.sv
bench/tb_rounded_rect_pixel_shader.sv
